// ----- sv/wfts_pkg.sv -----
// Shared types and constants for the windowed frame-time statistics block.
`default_nettype none

package wfts_pkg;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Register reset value and average clamp
  localparam logic [15:0] WINDOW_MS_RESET = 16'd1000;
  localparam logic [15:0] AVG_CLAMP       = 16'hFFFF;

  // History selector of the all-modes history
  localparam logic [2:0] ARR_ALL = 3'd0;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_DIV_START,
    S_DIV_WAIT,
    S_PUSH_ALL,
    S_PUSH_MODE,
    S_RD_ADDR,
    S_RD_MEM,
    S_DONE
  } state_t;

  // Commands to the history store
  typedef struct packed {
    logic       push;
    logic       lookup;
    logic [2:0] sel;
  } hist_ctrl_t;

  // Status of the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- sv/wfts_div.sv -----
// Bit-serial divider producing the clamped 16-bit window average.
`default_nettype none

module wfts_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         dividend,
  input  logic [15:0]         divisor,
  output wfts_pkg::div_stat_t stat,
  output logic [15:0]         quotient
);
  import wfts_pkg::*;

  logic [15:0] rem;
  logic [15:0] dsr;
  logic [15:0] quo;
  logic [3:0]  cnt;
  logic        active;
  logic        done;
  logic [16:0] wide;
  logic [16:0] diff;
  logic        qbit;
  logic        clamp;

  // Quotient does not fit in 16 bits when the upper half reaches the divisor
  assign clamp = (dividend[31:16] >= divisor);

  // One restoring step: bring down the next dividend bit and try a subtract
  assign wide = {rem, quo[15]};
  assign diff = wide - {1'b0, dsr};
  assign qbit = (wide >= {1'b0, dsr});

  // Advance the division one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (clamp) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          active <= 1'b1;
        end
      end else if (active) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Shift the partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= dividend[31:16];
      quo <= clamp ? AVG_CLAMP : dividend[15:0];
    end else if (active) begin
      rem <= qbit ? diff[15:0] : wide[15:0];
      quo <= {quo[14:0], qbit};
    end
  end

  assign stat.busy = active;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

`default_nettype wire

// ----- sv/wfts_hist.sv -----
// Average histories: circular buffers in one memory with fill counts per history.
`default_nettype none

module wfts_hist #(
  parameter int HISTORY_DEPTH = 64,
  parameter int MODE_COUNT    = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wfts_pkg::hist_ctrl_t ctrl,
  input  logic [15:0]          push_value,
  input  logic [5:0]           read_index,
  output logic [15:0]          read_value
);
  import wfts_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int AR = $clog2(MODE_COUNT + 1);
  localparam int CW = (AW + 1 > 6) ? AW + 1 : 6;
  localparam int NH = MODE_COUNT + 1;

  logic [15:0]   mem  [0:NH-1][0:HISTORY_DEPTH-1];
  logic [AW-1:0] head [0:NH-1];
  logic [FW-1:0] fill [0:NH-1];

  logic [AR-1:0] sel_idx;
  logic          sel_ok;
  logic [CW-1:0] slot_raw;
  logic [CW-1:0] slot_wrap;
  logic          hit;

  logic [AR-1:0] rd_arr;
  logic [AW-1:0] rd_slot;
  logic          rd_ok;
  logic [15:0]   rdata;
  logic          rdata_ok;

  assign sel_idx = ctrl.sel[AR-1:0];
  assign sel_ok  = ({5'd0, ctrl.sel} <= 8'(MODE_COUNT));

  // Newest entry sits just behind the write head
  assign slot_raw  = CW'(head[sel_idx]) + CW'(HISTORY_DEPTH - 1) - CW'(read_index);
  assign slot_wrap = (slot_raw >= CW'(HISTORY_DEPTH)) ? slot_raw - CW'(HISTORY_DEPTH)
                                                     : slot_raw;
  // Entries beyond the fill count were never written and read as zero
  assign hit = sel_ok && (CW'(read_index) < CW'(fill[sel_idx]));

  // Advance write heads and fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NH; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else if (ctrl.push) begin
      head[sel_idx] <= (head[sel_idx] == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                 : head[sel_idx] + AW'(1);
      if (fill[sel_idx] != FW'(HISTORY_DEPTH)) begin
        fill[sel_idx] <= fill[sel_idx] + FW'(1);
      end
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[sel_idx][head[sel_idx]] <= push_value;
    end
  end

  // Capture the lookup address
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else if (ctrl.lookup) begin
      rd_ok <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.lookup) begin
      rd_arr  <= sel_idx;
      rd_slot <= slot_wrap[AW-1:0];
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata    <= mem[rd_arr][rd_slot];
    rdata_ok <= rd_ok;
  end

  assign read_value = rdata_ok ? rdata : 16'd0;

endmodule

`default_nettype wire

// ----- sv/windowed_frame_time_stats.sv -----
// Top level: window accumulators, controller, output register and submodules.
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transaction: a
//   timing sample (kind 0) or a history read (kind 1). Every item yields
//   exactly one result on the output channel (out_valid/out_ready).
//   Items are handled one at a time by a sequencer.
//   A sample that keeps the window open is folded into the accumulators. A
//   sample that closes the window also runs the divider (skipped when the
//   average clamps), then pushes the average into the all-modes history
//   and, when the mode has its own history, into that one as well. A
//   history read passes an address step and a registered memory read.
//   The divider is bit-serial and the history memory has a single write
//   port (one push per cycle). The next item is taken as soon as the
//   sequencer is idle, even while the previous result still waits in the
//   output register; a stalled receiver holds the finished result there
//   and the sequencer then waits. window_ms is written through
//   cfg_we/cfg_wdata; the user must write it only while idle, as the
//   block itself does not enforce this.
//   Reset (rst, synchronous) empties the window, zeroes the latched
//   statistics and empties all histories; no clearing pass is needed.
`default_nettype none

module windowed_frame_time_stats #(
  parameter int HISTORY_DEPTH = 64,
  parameter int MODE_COUNT    = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [31:0] time_all,
  input  logic [15:0] frame_time,
  input  logic [2:0]  mode,
  input  logic [2:0]  read_array,
  input  logic [5:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        window_closed,
  output logic [15:0] average_time,
  output logic [15:0] max_time,
  output logic [15:0] min_time,
  output logic [15:0] start_time,
  output logic [15:0] stop_time,
  output logic [15:0] read_value
);
  import wfts_pkg::*;

  state_t state;
  state_t state_next;

  logic        in_take;
  logic        out_load;
  logic        div_start;
  hist_ctrl_t  hist_ctrl;
  div_stat_t   div_stat;
  logic [15:0] div_quo;
  logic [15:0] hist_value;
  logic        mode_has_hist;

  // Captured item
  logic        kind_q;
  logic [31:0] time_q;
  logic [15:0] ft_q;
  logic [2:0]  mode_q;
  logic [2:0]  rarr_q;
  logic [5:0]  ridx_q;

  // Window state
  logic [15:0] window_ms;
  logic [31:0] window_start;
  logic [31:0] sample_sum;
  logic [15:0] sample_count;
  logic [15:0] running_max;
  logic [15:0] running_min;
  logic [15:0] first_sample;
  logic        closed;

  // Latched statistics
  logic [15:0] avg_lat;
  logic [15:0] max_lat;
  logic [15:0] min_lat;
  logic [15:0] stop_lat;

  logic [32:0] sum_ext;
  logic [31:0] elapsed;

  assign sum_ext       = {1'b0, sample_sum} + {17'd0, ft_q};
  assign elapsed       = time_q - window_start;
  assign mode_has_hist = (mode_q != 3'd0) && ({5'd0, mode_q} <= 8'(MODE_COUNT));

  assign in_take  = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_take) state_next = (kind == KIND_READ) ? S_RD_ADDR : S_ACC;
      S_ACC:       state_next = (elapsed >= {16'd0, window_ms}) ? S_DIV_START : S_DONE;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (div_stat.done) state_next = S_PUSH_ALL;
      S_PUSH_ALL:  state_next = mode_has_hist ? S_PUSH_MODE : S_DONE;
      S_PUSH_MODE: state_next = S_DONE;
      S_RD_ADDR:   state_next = S_RD_MEM;
      S_RD_MEM:    state_next = S_DONE;
      S_DONE:      if (out_load) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready       = 1'b0;
    div_start      = 1'b0;
    hist_ctrl.push   = 1'b0;
    hist_ctrl.lookup = 1'b0;
    hist_ctrl.sel    = ARR_ALL;
    case (state)
      S_IDLE:      in_ready = 1'b1;
      S_DIV_START: div_start = 1'b1;
      S_PUSH_ALL: begin
        hist_ctrl.push = 1'b1;
        hist_ctrl.sel  = ARR_ALL;
      end
      S_PUSH_MODE: begin
        hist_ctrl.push = 1'b1;
        hist_ctrl.sel  = mode_q;
      end
      S_RD_ADDR: begin
        hist_ctrl.lookup = 1'b1;
        hist_ctrl.sel    = rarr_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item on its transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_q <= kind;
      time_q <= time_all;
      ft_q   <= frame_time;
      mode_q <= mode;
      rarr_q <= read_array;
      ridx_q <= read_index;
    end
  end

  // Window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WINDOW_MS_RESET;
    end else if (cfg_we) begin
      window_ms <= cfg_wdata;
    end
  end

  // Fold samples into the window, then restart it at close
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      sample_sum   <= '0;
      sample_count <= '0;
      running_max  <= '0;
      running_min  <= '0;
      first_sample <= '0;
      closed       <= 1'b0;
      avg_lat      <= '0;
      max_lat      <= '0;
      min_lat      <= '0;
      stop_lat     <= '0;
    end else begin
      if (in_take) begin
        closed <= 1'b0;
      end
      if (state == S_ACC) begin
        if (sample_count == 16'd0) begin
          first_sample <= ft_q;
          running_max  <= ft_q;
          running_min  <= ft_q;
        end else begin
          if (ft_q > running_max) running_max <= ft_q;
          if (ft_q < running_min) running_min <= ft_q;
        end
        sample_sum <= sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
        if (sample_count != 16'hFFFF) begin
          sample_count <= sample_count + 16'd1;
        end
        closed <= (elapsed >= {16'd0, window_ms});
      end
      if ((state == S_DIV_WAIT) && div_stat.done) begin
        avg_lat      <= div_quo;
        max_lat      <= running_max;
        min_lat      <= running_min;
        stop_lat     <= ft_q;
        window_start <= time_q;
        sample_sum   <= '0;
        sample_count <= '0;
        running_max  <= '0;
        running_min  <= '0;
      end
    end
  end

  wfts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sample_sum),
    .divisor  (sample_count),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  wfts_hist #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MODE_COUNT    (MODE_COUNT)
  ) u_hist (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (hist_ctrl),
    .push_value (avg_lat),
    .read_index (ridx_q),
    .read_value (hist_value)
  );

  // Output register: hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      window_closed <= (kind_q == KIND_SAMPLE) && closed;
      average_time  <= avg_lat;
      max_time      <= max_lat;
      min_time      <= min_lat;
      start_time    <= first_sample;
      stop_time     <= stop_lat;
      read_value    <= (kind_q == KIND_READ) ? hist_value : 16'd0;
    end
  end

endmodule

`default_nettype wire

// ----- verif/windowed_frame_time_stats_tb.sv -----
// Testbench for windowed_frame_time_stats: directed table, random traffic, scoreboard check.
`timescale 1ns / 100ps

module windowed_frame_time_stats_tb;
  import wfts_pkg::*;

  localparam int HIST_DEPTH  = 64;
  localparam int MODE_COUNT  = 5;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 240;
  // Selector above the last mode history; reads return zero
  localparam logic [2:0] ARR_NONE = 3'd7;
  // Window length per random phase: shortest nonzero, zero, longest, then middling
  localparam logic [5:0][15:0] PHASE_WINDOW =
    {16'd4096, 16'd37, 16'd1000, 16'hFFFF, 16'd0, 16'd1};

  typedef struct packed {
    logic        kind;
    logic [31:0] time_all;
    logic [15:0] frame_time;
    logic [2:0]  mode;
    logic [2:0]  read_array;
    logic [5:0]  read_index;
  } stim_t;

  typedef struct packed {
    logic        window_closed;
    logic [15:0] average_time;
    logic [15:0] max_time;
    logic [15:0] min_time;
    logic [15:0] start_time;
    logic [15:0] stop_time;
    logic [15:0] read_value;
  } stats_t;

  typedef struct packed {
    stim_t  item;
    logic   typed;
    stats_t want;
  } table_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [31:0] time_all;
  logic [15:0] frame_time;
  logic [2:0]  mode;
  logic [2:0]  read_array;
  logic [5:0]  read_index;
  logic        out_valid;
  logic        out_ready;
  logic        window_closed;
  logic [15:0] average_time;
  logic [15:0] max_time;
  logic [15:0] min_time;
  logic [15:0] start_time;
  logic [15:0] stop_time;
  logic [15:0] read_value;

  // Predicted block state
  logic [15:0] win_len;
  logic [31:0] win_start;
  logic [31:0] acc_sum;
  logic [15:0] acc_count;
  logic [15:0] acc_max;
  logic [15:0] acc_min;
  logic [15:0] acc_first;
  logic [15:0] last_avg;
  logic [15:0] last_max;
  logic [15:0] last_min;
  logic [15:0] last_stop;
  logic [15:0] hist_all [HIST_DEPTH];
  logic [15:0] hist_mode [MODE_COUNT][HIST_DEPTH];

  stats_t     pending_stats [$];
  table_row_t directed_rows [$];
  logic [31:0] clock_ms;
  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int result_count;

  windowed_frame_time_stats #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .MODE_COUNT(MODE_COUNT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .time_all(time_all),
    .frame_time(frame_time),
    .mode(mode),
    .read_array(read_array),
    .read_index(read_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .window_closed(window_closed),
    .average_time(average_time),
    .max_time(max_time),
    .min_time(min_time),
    .start_time(start_time),
    .stop_time(stop_time),
    .read_value(read_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Fold one accepted item into the predicted state and return its result
  function automatic stats_t fold_item(input stim_t it);
    stats_t      res;
    logic [31:0] span;
    logic [31:0] quot;
    res = '0;
    if (it.kind == KIND_SAMPLE) begin
      if (acc_count == 16'd0) begin
        acc_first = it.frame_time;
        acc_max   = it.frame_time;
        acc_min   = it.frame_time;
      end
      if (it.frame_time > acc_max) acc_max = it.frame_time;
      if (it.frame_time < acc_min) acc_min = it.frame_time;
      if (acc_sum > 32'hFFFF_FFFF - {16'd0, it.frame_time}) begin
        acc_sum = 32'hFFFF_FFFF;
      end else begin
        acc_sum = acc_sum + {16'd0, it.frame_time};
      end
      if (acc_count != 16'hFFFF) acc_count = acc_count + 16'd1;
      span = it.time_all - win_start;
      // Close the window: latch, restart, push the average
      if (span >= {16'd0, win_len}) begin
        quot = acc_sum / {16'd0, acc_count};
        if (quot > 32'h0000_FFFF) quot = 32'h0000_FFFF;
        last_avg  = quot[15:0];
        last_max  = acc_max;
        last_min  = acc_min;
        last_stop = it.frame_time;
        win_start = it.time_all;
        acc_sum   = '0;
        acc_count = '0;
        acc_max   = '0;
        acc_min   = '0;
        for (int i = HIST_DEPTH - 1; i > 0; i--) hist_all[i] = hist_all[i - 1];
        hist_all[0] = last_avg;
        if (it.mode >= 3'd1 && int'(it.mode) <= MODE_COUNT) begin
          for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            hist_mode[int'(it.mode) - 1][i] = hist_mode[int'(it.mode) - 1][i - 1];
          end
          hist_mode[int'(it.mode) - 1][0] = last_avg;
        end
        res.window_closed = 1'b1;
      end
    end else if (int'(it.read_index) < HIST_DEPTH) begin
      if (it.read_array == ARR_ALL) begin
        res.read_value = hist_all[it.read_index];
      end else if (int'(it.read_array) <= MODE_COUNT) begin
        res.read_value = hist_mode[int'(it.read_array) - 1][it.read_index];
      end
    end
    res.average_time = last_avg;
    res.max_time     = last_max;
    res.min_time     = last_min;
    res.start_time   = acc_first;
    res.stop_time    = last_stop;
    return res;
  endfunction

  // Draw a random item; samples mostly advance the clock by a fraction of the window
  function automatic stim_t random_item();
    stim_t       it;
    int          pick;
    logic [31:0] step_max;
    it.kind       = KIND_SAMPLE;
    it.time_all   = $urandom;
    it.frame_time = 16'($urandom_range(0, 65535));
    it.mode       = 3'($urandom_range(0, 7));
    it.read_array = 3'($urandom_range(0, 7));
    it.read_index = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 99) < 25) begin
      it.kind = KIND_READ;
    end else begin
      pick     = $urandom_range(0, 99);
      step_max = {16'd0, win_len} / 4 + 1;
      if (pick < 3) begin
        clock_ms = $urandom;
      end else if (pick < 10) begin
        clock_ms = clock_ms + $urandom_range(0, 3 * {16'd0, win_len} + 2);
      end else begin
        clock_ms = clock_ms + $urandom_range(0, step_max);
      end
      it.time_all = clock_ms;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        it.frame_time = 16'd0;
      end else if (pick < 16) begin
        it.frame_time = 16'hFFFF;
      end else if (pick < 60) begin
        it.frame_time = 16'($urandom_range(8, 40));
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got 0x%04h expected 0x%04h",
                                result_count, name, got, want));
    end
  endtask

  task automatic add_row(input logic k, input logic [31:0] t, input logic [15:0] ft,
                         input logic [2:0] md, input logic [2:0] arr,
                         input logic [5:0] idx, input logic typed, input stats_t want);
    table_row_t row;
    row.item  = '{kind: k, time_all: t, frame_time: ft, mode: md,
                  read_array: arr, read_index: idx};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Offer one transaction, hold it until accepted, then record its expected result
  task automatic send_item(input stim_t it, input logic use_typed, input stats_t typed_want);
    stats_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    kind       <= it.kind;
    time_all   <= it.time_all;
    frame_time <= it.frame_time;
    mode       <= it.mode;
    read_array <= it.read_array;
    read_index <= it.read_index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = fold_item(it);
    pending_stats.push_back(use_typed ? typed_want : predicted);
  endtask

  // Drain the block, let it settle, then write the window length
  task automatic set_window(input logic [15:0] len);
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we  <= 1'b0;
    win_len = len;
  endtask

  // Result side: randomly stall, check every accepted transaction
  initial begin
    stats_t got;
    stats_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        result_count++;
        got = '{window_closed: window_closed, average_time: average_time,
                max_time: max_time, min_time: min_time, start_time: start_time,
                stop_time: stop_time, read_value: read_value};
        if (pending_stats.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    result_count));
        end else begin
          want = pending_stats.pop_front();
          compare_field("window_closed", {15'd0, got.window_closed},
                        {15'd0, want.window_closed});
          compare_field("average_time", got.average_time, want.average_time);
          compare_field("max_time", got.max_time, want.max_time);
          compare_field("min_time", got.min_time, want.min_time);
          compare_field("start_time", got.start_time, want.start_time);
          compare_field("stop_time", got.stop_time, want.stop_time);
          compare_field("read_value", got.read_value, want.read_value);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Stop a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** windowed_frame_time_stats: FAILED **");
    $finish;
  end

  initial begin
    stats_t zero_stats;
    stats_t fresh_stats;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    kind       <= KIND_SAMPLE;
    time_all   <= '0;
    frame_time <= '0;
    mode       <= '0;
    read_array <= '0;
    read_index <= '0;
    mismatch_count = 0;
    result_count   = 0;
    send_idle_pct  = 23;
    recv_idle_pct  = 67;

    // Predicted state after reset
    win_len   = WINDOW_MS_RESET;
    win_start = '0;
    acc_sum   = '0;
    acc_count = '0;
    acc_max   = '0;
    acc_min   = '0;
    acc_first = '0;
    last_avg  = '0;
    last_max  = '0;
    last_min  = '0;
    last_stop = '0;
    foreach (hist_all[i]) hist_all[i] = '0;
    foreach (hist_mode[m, i]) hist_mode[m][i] = '0;

    // Directed table; known results typed in for the fresh-reset rows
    zero_stats  = '0;
    fresh_stats = '0;
    fresh_stats.start_time = 16'hFFFF;
    add_row(KIND_READ,   32'd0,         16'd0,     3'd0, ARR_ALL,  6'd0,  1'b1, zero_stats);
    add_row(KIND_READ,   32'hFFFF_FFFF, 16'hFFFF,  3'd7, ARR_NONE, 6'd63, 1'b1, zero_stats);
    add_row(KIND_READ,   32'd0,         16'd0,     3'd0, 3'd5,     6'd63, 1'b1, zero_stats);
    add_row(KIND_SAMPLE, 32'd0,         16'hFFFF,  3'd0, ARR_ALL,  6'd0,  1'b1, fresh_stats);
    add_row(KIND_SAMPLE, 32'd999,       16'd0,     3'd1, ARR_ALL,  6'd0,  1'b1, fresh_stats);
    add_row(KIND_SAMPLE, 32'd1000,      16'd3,     3'd5, ARR_ALL,  6'd0,  1'b0, zero_stats);
    add_row(KIND_READ,   32'd0,         16'd0,     3'd0, 3'd5,     6'd0,  1'b0, zero_stats);
    add_row(KIND_READ,   32'd0,         16'd0,     3'd0, ARR_ALL,  6'd0,  1'b0, zero_stats);
    add_row(KIND_SAMPLE, 32'd2999,      16'd100,   3'd2, ARR_ALL,  6'd0,  1'b0, zero_stats);
    add_row(KIND_SAMPLE, 32'd3000,      16'd200,   3'd3, ARR_ALL,  6'd0,  1'b0, zero_stats);
    add_row(KIND_SAMPLE, 32'hFFFF_FFFF, 16'd1,     3'd3, ARR_ALL,  6'd0,  1'b0, zero_stats);
    add_row(KIND_SAMPLE, 32'd998,       16'd7,     3'd4, ARR_ALL,  6'd0,  1'b0, zero_stats);
    add_row(KIND_SAMPLE, 32'd999,       16'd9,     3'd6, ARR_ALL,  6'd0,  1'b0, zero_stats);
    add_row(KIND_SAMPLE, 32'd5000,      16'd0,     3'd7, ARR_ALL,  6'd0,  1'b0, zero_stats);
    add_row(KIND_SAMPLE, 32'd6000,      16'hFFFF,  3'd4, ARR_ALL,  6'd0,  1'b0, zero_stats);
    add_row(KIND_READ,   32'd0,         16'd0,     3'd0, 3'd1,     6'd0,  1'b0, zero_stats);
    add_row(KIND_READ,   32'd0,         16'd0,     3'd0, 3'd2,     6'd0,  1'b0, zero_stats);
    add_row(KIND_READ,   32'd0,         16'd0,     3'd0, 3'd3,     6'd0,  1'b0, zero_stats);
    add_row(KIND_READ,   32'd0,         16'd0,     3'd0, 3'd4,     6'd0,  1'b0, zero_stats);
    add_row(KIND_READ,   32'd0,         16'd0,     3'd0, 3'd6,     6'd0,  1'b0, zero_stats);
    add_row(KIND_READ,   32'd0,         16'd0,     3'd0, ARR_ALL,  6'd5,  1'b0, zero_stats);
    add_row(KIND_READ,   32'd0,         16'd0,     3'd0, ARR_ALL,  6'd63, 1'b0, zero_stats);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
    end

    // Random phases: swap idling after two phases, then run without idling
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 67;
        recv_idle_pct = 23;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_window(PHASE_WINDOW[p]);
      clock_ms = $urandom;
      repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, zero_stats);
    end

    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** windowed_frame_time_stats: PASSED **");
    end else begin
      $display("** windowed_frame_time_stats: FAILED **");
    end
    $finish;
  end

endmodule
